@@ rtl/core/wifi_security_ie_parser_assert.svh @@
// assertion macros shared by the security element parser modules
`ifndef WIFI_SECURITY_IE_PARSER_ASSERT_SVH
`define WIFI_SECURITY_IE_PARSER_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define WSIEP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("wsiep check failed");

// next-cycle implication, disabled while reset is held
`define WSIEP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("wsiep check failed");

`endif

@@ rtl/core/wsiep_pkg.sv @@
// shared types, constants and lookup functions of the security element parser
package wsiep_pkg;

    // element tags
    localparam logic [7:0] TAG_RSN    = 8'h30;
    localparam logic [7:0] TAG_VENDOR = 8'hDD;

    // suite types below this value map to a mask bit
    localparam logic [7:0] MASK_TYPES = 8'd8;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // input beat
    typedef struct packed {
        logic [7:0] ie_byte;
        logic       last_byte;
    } t_in_item;

    // result beat
    typedef struct packed {
        logic       has_wpa;
        logic       has_rsn;
        logic [7:0] cipher_mask;
        logic [7:0] keymgmt_mask;
        logic       truncated;
    } t_out_item;

    // classified byte held in the queue
    typedef struct packed {
        logic [7:0] ie_byte;
        logic       last_byte;
        logic       is_rsn_tag;
        logic       is_vendor_tag;
        logic       is_small_type;
    } t_cls_item;

    // rsn suite oui 00:0f:ac
    function automatic logic [7:0] rsn_oui_byte(input logic [1:0] idx);
        logic [7:0] v;
        unique case (idx)
            2'd0:    v = 8'h00;
            2'd1:    v = 8'h0F;
            default: v = 8'hAC;
        endcase
        return v;
    endfunction

    // wpa vendor header 00:50:f2:01
    function automatic logic [7:0] wpa_hdr_byte(input logic [1:0] idx);
        logic [7:0] v;
        unique case (idx)
            2'd0:    v = 8'h00;
            2'd1:    v = 8'h50;
            2'd2:    v = 8'hF2;
            default: v = 8'h01;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/wsiep_front.sv @@
// front end: classifies incoming bytes and queues them for the parser
`include "wifi_security_ie_parser_assert.svh"

module wsiep_front #(
    parameter int DEPTH = wsiep_pkg::QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  wsiep_pkg::t_in_item  i_data,
    output logic                 o_pop_valid,
    input  logic                 i_pop_ready,
    output wsiep_pkg::t_cls_item o_pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    wsiep_pkg::t_cls_item r_mem [DEPTH];
    logic [PTR_W-1:0]     r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]     r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]     r_count, n_count;
    wsiep_pkg::t_cls_item w_cls;
    logic                 w_push;
    logic                 w_pop;

    // byte classification, independent of parser state
    always_comb begin
        w_cls.ie_byte       = i_data.ie_byte;
        w_cls.last_byte     = i_data.last_byte;
        w_cls.is_rsn_tag    = (i_data.ie_byte == wsiep_pkg::TAG_RSN);
        w_cls.is_vendor_tag = (i_data.ie_byte == wsiep_pkg::TAG_VENDOR);
        w_cls.is_small_type = (i_data.ie_byte < wsiep_pkg::MASK_TYPES);
    end

    // queue handshakes
    assign o_ready     = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid = (r_count != '0);
    assign o_pop_data  = r_mem[r_rd_ptr];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = o_pop_valid && i_pop_ready;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_cls;
        end
    end

    // fill count tracks pushes and pops
    `WSIEP_ASSERT_NEXT(a_cnt_up, i_clk, i_rst_n, w_push && !w_pop, r_count == $past(r_count) + 1'b1)
    `WSIEP_ASSERT_NEXT(a_cnt_dn, i_clk, i_rst_n, w_pop && !w_push, r_count == $past(r_count) - 1'b1)
    `WSIEP_ASSERT_SAME(a_cnt_max, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH))

endmodule

@@ rtl/core/wsiep_back.sv @@
// back end: element walker, suite mask collection and result register
`include "wifi_security_ie_parser_assert.svh"

module wsiep_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_pop_valid,
    output logic                 o_pop_ready,
    input  wsiep_pkg::t_cls_item i_pop_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output wsiep_pkg::t_out_item o_data
);

    typedef enum logic [8:0] {
        PH_TAG    = 9'b000000001,
        PH_LEN    = 9'b000000010,
        PH_WPAHDR = 9'b000000100,
        PH_FIXED  = 9'b000001000,
        PH_PCOUNT = 9'b000010000,
        PH_PSUITE = 9'b000100000,
        PH_ACOUNT = 9'b001000000,
        PH_ASUITE = 9'b010000000,
        PH_SKIP   = 9'b100000000
    } t_phase;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_RSN  = 2'd1,
        KIND_WPA  = 2'd2
    } t_kind;

    t_phase               r_phase, n_phase;
    t_kind                r_kind, n_kind;
    logic [7:0]           r_bytes_left, n_bytes_left;
    logic [2:0]           r_hdr_idx, n_hdr_idx;
    logic [15:0]          r_suites_left, n_suites_left;
    logic [1:0]           r_sb_idx, n_sb_idx;
    logic                 r_oui_match, n_oui_match;
    logic                 r_seen_wpa, n_seen_wpa;
    logic                 r_seen_rsn, n_seen_rsn;
    logic [7:0]           r_cipher, n_cipher;
    logic [7:0]           r_akm, n_akm;
    logic                 r_out_valid, n_out_valid;
    wsiep_pkg::t_out_item r_out_data, n_out_data;

    logic                 w_fire;
    logic                 w_out_free;
    logic [7:0]           w_byte;
    logic [7:0]           w_oui_exp;
    logic                 w_oui_ok;
    logic [15:0]          w_sl_dec;
    logic [15:0]          w_sl_full;
    logic [7:0]           w_type_bit;
    logic [7:0]           w_bl_dec;
    logic                 w_suite_ph;
    logic                 w_hdr_ok;
    logic                 w_last_fire;
    logic                 w_cleared;

    // a last byte needs the result register free
    assign w_out_free  = !r_out_valid || i_ready;
    assign o_pop_ready = !i_pop_data.last_byte || w_out_free;
    assign w_fire      = i_pop_valid && o_pop_ready;
    assign w_byte      = i_pop_data.ie_byte;

    // suite byte helpers
    assign w_oui_exp  = (r_kind == KIND_RSN) ? wsiep_pkg::rsn_oui_byte(r_sb_idx)
                                             : wsiep_pkg::wpa_hdr_byte(r_sb_idx);
    assign w_oui_ok   = (w_byte == w_oui_exp);
    assign w_sl_dec   = r_suites_left - 16'd1;
    assign w_sl_full  = {w_byte, r_suites_left[7:0]};
    assign w_type_bit = (r_oui_match && i_pop_data.is_small_type)
                        ? (8'b1 << w_byte[2:0]) : 8'b0;
    assign w_bl_dec   = r_bytes_left - 8'd1;

    // per-byte parser step
    always_comb begin
        n_phase       = r_phase;
        n_kind        = r_kind;
        n_bytes_left  = r_bytes_left;
        n_hdr_idx     = r_hdr_idx;
        n_suites_left = r_suites_left;
        n_sb_idx      = r_sb_idx;
        n_oui_match   = r_oui_match;
        n_seen_wpa    = r_seen_wpa;
        n_seen_rsn    = r_seen_rsn;
        n_cipher      = r_cipher;
        n_akm         = r_akm;
        n_out_data    = r_out_data;
        n_out_valid   = r_out_valid && !i_ready;

        if (w_fire) begin
            if (r_phase == PH_TAG) begin
                // tag byte picks the element kind
                if (i_pop_data.is_rsn_tag && !r_seen_rsn) begin
                    n_seen_rsn = 1'b1;
                    n_kind     = KIND_RSN;
                end else if (i_pop_data.is_vendor_tag && !r_seen_wpa) begin
                    n_kind = KIND_WPA;
                end else begin
                    n_kind = KIND_NONE;
                end
                n_phase = PH_LEN;
            end else if (r_phase == PH_LEN) begin
                // length byte opens the body
                n_bytes_left = w_byte;
                n_hdr_idx    = '0;
                n_sb_idx     = '0;
                n_oui_match  = 1'b1;
                if (w_byte == 8'd0) begin
                    n_phase = PH_TAG;
                    n_kind  = KIND_NONE;
                end else if (r_kind == KIND_RSN) begin
                    n_phase = PH_FIXED;
                end else if (r_kind == KIND_WPA) begin
                    n_phase = PH_WPAHDR;
                end else begin
                    n_phase = PH_SKIP;
                end
            end else begin
                // body bytes
                unique case (r_phase)
                    PH_WPAHDR: begin
                        if (w_byte != wsiep_pkg::wpa_hdr_byte(r_hdr_idx[1:0])) begin
                            n_kind  = KIND_NONE;
                            n_phase = PH_SKIP;
                        end else if (r_hdr_idx >= 3'd3) begin
                            n_seen_wpa = 1'b1;
                            n_hdr_idx  = '0;
                            n_phase    = PH_FIXED;
                        end else begin
                            n_hdr_idx = r_hdr_idx + 3'd1;
                        end
                    end
                    PH_FIXED: begin
                        if (r_hdr_idx >= 3'd5) begin
                            n_hdr_idx = '0;
                            n_phase   = PH_PCOUNT;
                        end else begin
                            n_hdr_idx = r_hdr_idx + 3'd1;
                        end
                    end
                    PH_PCOUNT, PH_ACOUNT: begin
                        if (r_hdr_idx == 3'd0) begin
                            n_suites_left = {8'd0, w_byte};
                            n_hdr_idx     = 3'd1;
                        end else begin
                            n_suites_left = w_sl_full;
                            n_hdr_idx     = '0;
                            n_sb_idx      = '0;
                            n_oui_match   = 1'b1;
                            if (r_phase == PH_PCOUNT) begin
                                n_phase = (w_sl_full == 16'd0) ? PH_ACOUNT : PH_PSUITE;
                            end else begin
                                n_phase = (w_sl_full == 16'd0) ? PH_SKIP : PH_ASUITE;
                            end
                        end
                    end
                    PH_PSUITE, PH_ASUITE: begin
                        if (r_sb_idx != 2'd3) begin
                            n_oui_match = r_oui_match && w_oui_ok;
                            n_sb_idx    = r_sb_idx + 2'd1;
                        end else begin
                            if (r_phase == PH_PSUITE) begin
                                n_cipher = r_cipher | w_type_bit;
                            end else begin
                                n_akm = r_akm | w_type_bit;
                            end
                            n_sb_idx      = '0;
                            n_oui_match   = 1'b1;
                            n_suites_left = w_sl_dec;
                            if (w_sl_dec == 16'd0) begin
                                if (r_phase == PH_PSUITE) begin
                                    n_hdr_idx = '0;
                                    n_phase   = PH_ACOUNT;
                                end else begin
                                    n_phase = PH_SKIP;
                                end
                            end
                        end
                    end
                    default: begin
                    end
                endcase
                // element end returns to tag
                n_bytes_left = w_bl_dec;
                if (w_bl_dec == 8'd0) begin
                    n_phase = PH_TAG;
                    n_kind  = KIND_NONE;
                end
            end

            // summary on the marked byte, then back to reset values
            if (i_pop_data.last_byte) begin
                n_out_valid             = 1'b1;
                n_out_data.has_wpa      = n_seen_wpa;
                n_out_data.has_rsn      = n_seen_rsn;
                n_out_data.cipher_mask  = n_cipher;
                n_out_data.keymgmt_mask = n_akm;
                n_out_data.truncated    = (n_phase != PH_TAG);
                n_phase       = PH_TAG;
                n_kind        = KIND_NONE;
                n_bytes_left  = '0;
                n_hdr_idx     = '0;
                n_suites_left = '0;
                n_sb_idx      = '0;
                n_oui_match   = 1'b1;
                n_seen_wpa    = 1'b0;
                n_seen_rsn    = 1'b0;
                n_cipher      = '0;
                n_akm         = '0;
            end
        end
    end

    // parser and result control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_TAG;
            r_kind        <= KIND_NONE;
            r_bytes_left  <= '0;
            r_hdr_idx     <= '0;
            r_suites_left <= '0;
            r_sb_idx      <= '0;
            r_oui_match   <= 1'b1;
            r_seen_wpa    <= 1'b0;
            r_seen_rsn    <= 1'b0;
            r_cipher      <= '0;
            r_akm         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_kind        <= n_kind;
            r_bytes_left  <= n_bytes_left;
            r_hdr_idx     <= n_hdr_idx;
            r_suites_left <= n_suites_left;
            r_sb_idx      <= n_sb_idx;
            r_oui_match   <= n_oui_match;
            r_seen_wpa    <= n_seen_wpa;
            r_seen_rsn    <= n_seen_rsn;
            r_cipher      <= n_cipher;
            r_akm         <= n_akm;
            r_out_valid   <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    // check terms
    assign w_suite_ph  = (r_phase == PH_PSUITE) || (r_phase == PH_ASUITE);
    assign w_hdr_ok    = (r_kind == KIND_WPA) && (r_hdr_idx <= 3'd3);
    assign w_last_fire = w_fire && i_pop_data.last_byte;
    assign w_cleared   = (r_phase == PH_TAG) && !r_seen_rsn && !r_seen_wpa;

    // suite phases always have suites pending
    `WSIEP_ASSERT_SAME(a_suites_pending, i_clk, i_rst_n, w_suite_ph, r_suites_left != 16'd0)
    // vendor header walk only for a candidate wpa element
    `WSIEP_ASSERT_SAME(a_wpahdr_kind, i_clk, i_rst_n, r_phase == PH_WPAHDR, w_hdr_ok)
    // marked byte yields a result and a cleared parser
    `WSIEP_ASSERT_NEXT(a_last_result, i_clk, i_rst_n, w_last_fire, r_out_valid && w_cleared)

endmodule

@@ rtl/core/wifi_security_ie_parser.sv @@
// top level of the 802.11 rsn / wpa security element parser
//
// Input channel (i_valid / o_ready / i_data): one byte of a beacon or probe
// response element area per beat, with last_byte set on the final byte.
// Output channel (o_valid / i_ready / o_data): one summary beat per area,
// giving wpa and rsn presence, pairwise cipher and akm suite masks and a
// truncation flag, after which the parser starts over on the next area.
// Throughput is one byte per cycle while o_ready is high; the walker in the
// back end updates its state once per byte and the front queue takes a byte
// every cycle unless it is full. From acceptance of the last byte to o_valid,
// the byte is first written into the classify queue and the walker then
// registers the summary in the result register.
// A stalled result register holds its beat; bytes keep flowing until the
// next last byte reaches the walker, then the queue fills and o_ready drops.
// Synchronous active-low reset empties the queue, drops o_valid and returns
// the walker to expecting a tag with all flags and masks cleared.
module wifi_security_ie_parser #(
    parameter int QUEUE_DEPTH = wsiep_pkg::QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  wsiep_pkg::t_in_item  i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output wsiep_pkg::t_out_item o_data
);

    logic                 w_pop_valid;
    logic                 w_pop_ready;
    wsiep_pkg::t_cls_item w_pop_data;

    // classify and queue
    wsiep_front #(
        .DEPTH(QUEUE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_pop_valid (w_pop_valid),
        .i_pop_ready (w_pop_ready),
        .o_pop_data  (w_pop_data)
    );

    // element walker and result register
    wsiep_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (w_pop_valid),
        .o_pop_ready (w_pop_ready),
        .i_pop_data  (w_pop_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the rsn / wpa security element parser
module tb;

    // walker phases and element kinds of the byte-level predictor
    typedef enum logic [3:0] {
        W_TAG, W_LEN, W_VHDR, W_FIXED, W_PCNT, W_PSUITE, W_ACNT, W_ASUITE, W_SKIP
    } t_walk_phase;
    typedef enum logic [1:0] {EL_OTHER, EL_RSN, EL_WPA} t_elem_kind;

    // one queued input beat, optionally held until all summaries are back
    typedef struct packed {
        wsiep_pkg::t_in_item beat;
        logic                wait_idle;
    } t_pend_beat;

    localparam logic [7:0]  RSN_TAG     = 8'h30;
    localparam logic [7:0]  VENDOR_TAG  = 8'hDD;
    localparam logic [23:0] RSN_OUI     = 24'h000FAC;
    localparam logic [31:0] WPA_HDR     = 32'h0050F201;
    localparam int          MAX_GAP     = 14;
    localparam int          IDLE_LIMIT  = 500;
    localparam int          TAIL_CYCLES = 16;
    localparam int          RAND_BYTES  = 900;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    wsiep_pkg::t_in_item  in_data = '0;
    logic                 out_ready = 1'b0;
    logic                 dut_ready;
    logic                 out_valid;
    wsiep_pkg::t_out_item out_data;

    wifi_security_ie_parser uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid),
        .o_ready (dut_ready),
        .i_data  (in_data),
        .o_valid (out_valid),
        .i_ready (out_ready),
        .o_data  (out_data)
    );

    // clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // predictor state
    t_walk_phase w_phase;
    t_elem_kind  w_kind;
    logic [7:0]  w_left;
    logic [2:0]  w_hdr;
    logic [15:0] w_suites;
    logic [1:0]  w_sidx;
    logic        w_oui_ok;
    logic        w_wpa;
    logic        w_rsn;
    logic [7:0]  w_cipher;
    logic [7:0]  w_akm;

    wsiep_pkg::t_out_item summary_q[$];
    t_pend_beat           pend_q[$];
    logic [7:0]           area_q[$];
    logic [7:0]           body_q[$];

    int n_predicted = 0;
    int n_checked = 0;
    int n_bytes = 0;
    int n_areas = 0;
    int err_cnt = 0;
    int n_rsn_seen = 0;
    int n_wpa_seen = 0;
    int n_trunc_seen = 0;

    task automatic clear_walker();
        w_phase  = W_TAG;
        w_kind   = EL_OTHER;
        w_left   = '0;
        w_hdr    = '0;
        w_suites = '0;
        w_sidx   = '0;
        w_oui_ok = 1'b1;
        w_wpa    = 1'b0;
        w_rsn    = 1'b0;
        w_cipher = '0;
        w_akm    = '0;
    endtask

    // expected oui byte of a suite inside the current element
    function automatic logic [7:0] suite_oui_byte(input logic [1:0] idx);
        return (w_kind == EL_RSN) ? RSN_OUI[23 - 8 * idx -: 8] : WPA_HDR[31 - 8 * idx -: 8];
    endfunction

    // little-endian suite count, low byte first
    task automatic count_step(input logic [7:0] b, input t_walk_phase suite_ph,
                              input t_walk_phase after_ph);
        if (w_hdr == 3'd0) begin
            w_suites = {8'h00, b};
            w_hdr = 3'd1;
        end else begin
            w_suites = {b, w_suites[7:0]};
            w_hdr = 3'd0;
            w_sidx = 2'd0;
            w_oui_ok = 1'b1;
            w_phase = (w_suites == 16'd0) ? after_ph : suite_ph;
        end
    endtask

    // one suite byte: three oui bytes then the type
    task automatic suite_step(input logic [7:0] b, inout logic [7:0] mask, output bit done);
        done = 1'b0;
        if (w_sidx < 2'd3) begin
            if (b != suite_oui_byte(w_sidx))
                w_oui_ok = 1'b0;
            w_sidx = w_sidx + 2'd1;
        end else begin
            if (w_oui_ok && b < 8'd8)
                mask[b[2:0]] = 1'b1;
            w_sidx = 2'd0;
            w_oui_ok = 1'b1;
            w_suites = w_suites - 16'd1;
            done = (w_suites == 16'd0);
        end
    endtask

    // advance the predictor by one accepted byte
    task automatic walk_ie_byte(input wsiep_pkg::t_in_item beat);
        logic [7:0]           b;
        bit                   done;
        wsiep_pkg::t_out_item s;
        b = beat.ie_byte;
        case (w_phase)
            W_TAG: begin
                if (b == RSN_TAG && !w_rsn) begin
                    w_rsn = 1'b1;
                    w_kind = EL_RSN;
                end else if (b == VENDOR_TAG && !w_wpa) begin
                    w_kind = EL_WPA;
                end else begin
                    w_kind = EL_OTHER;
                end
                w_phase = W_LEN;
            end
            W_LEN: begin
                w_left = b;
                w_hdr = 3'd0;
                w_sidx = 2'd0;
                w_oui_ok = 1'b1;
                if (b == 8'd0) begin
                    w_phase = W_TAG;
                    w_kind = EL_OTHER;
                end else if (w_kind == EL_RSN) begin
                    w_phase = W_FIXED;
                end else if (w_kind == EL_WPA) begin
                    w_phase = W_VHDR;
                end else begin
                    w_phase = W_SKIP;
                end
            end
            default: begin
                case (w_phase)
                    W_VHDR: begin
                        if (b != WPA_HDR[31 - 8 * w_hdr[1:0] -: 8]) begin
                            w_kind = EL_OTHER;
                            w_phase = W_SKIP;
                        end else if (w_hdr >= 3'd3) begin
                            w_wpa = 1'b1;
                            w_hdr = 3'd0;
                            w_phase = W_FIXED;
                        end else begin
                            w_hdr = w_hdr + 3'd1;
                        end
                    end
                    // version and group suite
                    W_FIXED: begin
                        if (w_hdr >= 3'd5) begin
                            w_hdr = 3'd0;
                            w_phase = W_PCNT;
                        end else begin
                            w_hdr = w_hdr + 3'd1;
                        end
                    end
                    W_PCNT: count_step(b, W_PSUITE, W_ACNT);
                    W_PSUITE: begin
                        suite_step(b, w_cipher, done);
                        if (done) begin
                            w_hdr = 3'd0;
                            w_phase = W_ACNT;
                        end
                    end
                    W_ACNT: count_step(b, W_ASUITE, W_SKIP);
                    W_ASUITE: begin
                        suite_step(b, w_akm, done);
                        if (done)
                            w_phase = W_SKIP;
                    end
                    default: ;
                endcase
                w_left = w_left - 8'd1;
                if (w_left == 8'd0) begin
                    w_phase = W_TAG;
                    w_kind = EL_OTHER;
                end
            end
        endcase
        // summary on the last byte, then start over
        if (beat.last_byte) begin
            s.has_wpa = w_wpa;
            s.has_rsn = w_rsn;
            s.cipher_mask = w_cipher;
            s.keymgmt_mask = w_akm;
            s.truncated = (w_phase != W_TAG);
            summary_q.push_back(s);
            n_predicted++;
            clear_walker();
        end
    endtask

    // move the area under construction into the send queue
    task automatic close_area(input bit hold);
        t_pend_beat p;
        int         k;
        for (k = 0; k < area_q.size(); k++) begin
            p.beat.ie_byte = area_q[k];
            p.beat.last_byte = (k == area_q.size() - 1);
            p.wait_idle = hold && (k == 0);
            pend_q.push_back(p);
        end
        area_q.delete();
        n_areas++;
    endtask

    task automatic add_bytes(input logic [79:0] v, input int n);
        int k;
        for (k = 0; k < n; k++)
            area_q.push_back(v[8 * (n - 1 - k) +: 8]);
    endtask

    // count plus suites, with odd counts, foreign ouis and large types mixed in
    task automatic add_suite_list(input logic [23:0] oui);
        int          n;
        int          cnt;
        logic [23:0] s_oui;
        n = $urandom_range(0, 3);
        cnt = n;
        if ($urandom_range(0, 9) == 0)
            cnt = n + $urandom_range(1, 2);
        if ($urandom_range(0, 19) == 0)
            cnt = cnt + 256 * $urandom_range(1, 255);
        body_q.push_back(cnt[7:0]);
        body_q.push_back(cnt[15:8]);
        repeat (n) begin
            s_oui = oui;
            if ($urandom_range(0, 7) == 0)
                s_oui = oui ^ (24'd1 << $urandom_range(0, 23));
            else if ($urandom_range(0, 15) == 0)
                s_oui = 24'($urandom);
            body_q.push_back(s_oui[23:16]);
            body_q.push_back(s_oui[15:8]);
            body_q.push_back(s_oui[7:0]);
            if ($urandom_range(0, 5) == 0)
                body_q.push_back(8'($urandom_range(8, 255)));
            else
                body_q.push_back(8'($urandom_range(0, 7)));
        end
    endtask

    // rsn or wpa element, mostly well formed, sometimes cut short
    task automatic add_sec_element(input bit is_wpa);
        int          k;
        int          full;
        int          len;
        logic [23:0] oui;
        body_q.delete();
        oui = RSN_OUI;
        if (is_wpa) begin
            for (k = 0; k < 4; k++)
                body_q.push_back(WPA_HDR[31 - 8 * k -: 8]);
            if ($urandom_range(0, 7) == 0) begin
                k = $urandom_range(0, 3);
                body_q[k] = body_q[k] ^ 8'(1 << $urandom_range(0, 7));
            end
            oui = WPA_HDR[31:8];
        end
        if ($urandom_range(0, 3) == 0) begin
            body_q.push_back(8'($urandom));
            body_q.push_back(8'($urandom));
        end else begin
            body_q.push_back(8'h01);
            body_q.push_back(8'h00);
        end
        repeat (4) body_q.push_back(8'($urandom));
        add_suite_list(oui);
        add_suite_list(oui);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) body_q.push_back(8'($urandom));
        full = body_q.size();
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, full - 1) : full;
        area_q.push_back(is_wpa ? VENDOR_TAG : RSN_TAG);
        area_q.push_back(8'(len));
        for (k = 0; k < len; k++)
            area_q.push_back(body_q[k]);
    endtask

    // any tag with random body, now and then a long one
    task automatic add_other_element();
        int len;
        len = ($urandom_range(0, 39) == 0) ? $urandom_range(9, 255) : $urandom_range(0, 8);
        area_q.push_back(8'($urandom));
        area_q.push_back(8'(len));
        repeat (len) area_q.push_back(8'($urandom));
    endtask

    task automatic add_random_area(input bit hold);
        int cut;
        int n_el;
        if ($urandom_range(0, 7) == 0) begin
            // plain noise
            repeat ($urandom_range(1, 10)) area_q.push_back(8'($urandom));
        end else begin
            n_el = ($urandom_range(0, 3) == 0) ? 3 : $urandom_range(1, 2);
            repeat (n_el) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: add_sec_element(1'b0);
                    4, 5, 6, 7: add_sec_element(1'b1);
                    default:    add_other_element();
                endcase
            end
            // end the area inside an element now and then
            if ($urandom_range(0, 5) == 0) begin
                cut = $urandom_range(1, (area_q.size() > 6) ? 6 : area_q.size() - 1);
                repeat (cut) void'(area_q.pop_back());
            end
        end
        close_area(hold);
    endtask

    // input driver
    int gap_left = 0;
    bit burst_tx = 1'b0;
    always @(posedge i_clk) begin
        t_pend_beat nxt;
        logic       nv;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            nv = in_valid;
            if (in_valid && dut_ready) begin
                walk_ie_byte(in_data);
                n_bytes++;
                nv = 1'b0;
            end
            if (!nv) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pend_q.size() > 0 &&
                             (!pend_q[0].wait_idle || n_predicted == n_checked)) begin
                    nxt = pend_q.pop_front();
                    in_data <= nxt.beat;
                    nv = 1'b1;
                    if ($urandom_range(0, 31) == 0)
                        burst_tx = !burst_tx;
                    gap_left = burst_tx ? 0 : $urandom_range(0, MAX_GAP);
                end
            end
            in_valid <= nv;
        end
    end

    // reports one field and returns 1 on mismatch
    function automatic int field_bad(input string nm, input logic [7:0] want,
                                     input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h got %h", $time, nm, want, got);
            return 1;
        end
        return 0;
    endfunction

    // result monitor with random back pressure
    int stall_left = 0;
    bit burst_rx = 1'b0;
    always @(posedge i_clk) begin
        wsiep_pkg::t_out_item want;
        logic                 nr;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            nr = out_ready;
            if (out_valid && out_ready) begin
                if (summary_q.size() == 0) begin
                    $display("%0t: unexpected summary beat, expected none got %h",
                             $time, out_data);
                    err_cnt++;
                end else begin
                    want = summary_q.pop_front();
                    err_cnt += field_bad("has_wpa", 8'(want.has_wpa), 8'(out_data.has_wpa));
                    err_cnt += field_bad("has_rsn", 8'(want.has_rsn), 8'(out_data.has_rsn));
                    err_cnt += field_bad("cipher_mask", want.cipher_mask,
                                         out_data.cipher_mask);
                    err_cnt += field_bad("keymgmt_mask", want.keymgmt_mask,
                                         out_data.keymgmt_mask);
                    err_cnt += field_bad("truncated", 8'(want.truncated),
                                         8'(out_data.truncated));
                    n_rsn_seen += int'(want.has_rsn);
                    n_wpa_seen += int'(want.has_wpa);
                    n_trunc_seen += int'(want.truncated);
                end
                n_checked <= n_checked + 1;
                if ($urandom_range(0, 15) == 0)
                    burst_rx = !burst_rx;
                stall_left = burst_rx ? 0 : $urandom_range(0, MAX_GAP);
                nr = (stall_left == 0);
            end else if (!out_ready) begin
                if (stall_left > 0)
                    stall_left--;
                nr = (stall_left == 0);
            end
            out_ready <= nr;
        end
    end

    // watchdog on cycles with no beat on either side
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (in_valid && dut_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // stimulus, reset and end of run
    initial begin
        int rand_start;
        clear_walker();

        // rsn element with empty body
        add_bytes(80'h3000, 2);
        close_area(1'b0);
        // area ends right after a tag
        add_bytes(80'hFF, 1);
        close_area(1'b0);
        // vendor element shorter than the wpa header
        add_bytes(80'hDD030050F2, 5);
        close_area(1'b0);
        // vendor element with wrong type
        add_bytes(80'hDD040050F202, 6);
        close_area(1'b0);
        // short rsn element, then the area ends on the next tag
        add_bytes(80'h30060100000FAC04DD, 9);
        close_area(1'b0);
        // zero tag alone
        add_bytes(80'h00, 1);
        close_area(1'b0);

        // random areas, every eighth one waits for the parser to drain
        rand_start = pend_q.size();
        while (pend_q.size() - rand_start < RAND_BYTES)
            add_random_area(n_areas % 8 == 6);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pend_q.size() != 0 || in_valid || n_predicted > n_checked)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("sent %0d bytes in %0d element areas with random gaps and stalls",
                 n_bytes, n_areas);
        $display("checked %0d summaries: %0d with rsn, %0d with wpa, %0d truncated",
                 n_checked, n_rsn_seen, n_wpa_seen, n_trunc_seen);
        if (err_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/wsiep_pkg.sv
rtl/core/wsiep_front.sv
rtl/core/wsiep_back.sv
rtl/core/wifi_security_ie_parser.sv
dv/tb.sv
